/* hdl/m4i_pkg.sv */
// ----------------------------------------------------------------------------
// m4i_pkg
// Shared types, codes and index helpers for the 4x4 adjugate inverse core.
// ----------------------------------------------------------------------------
package m4i_pkg;

    localparam int DET_BITS = 64;
    localparam int META_BITS = 2 + DET_BITS;    // out_row + det_value
    localparam logic [1:0] ROW_LAST = 2'd3;
    localparam logic [2:0] TERM_LAST = 3'd5;
    localparam logic [2:0] TERM_NEG_FIRST = 3'd3;
    localparam logic [3:0] COF_LAST = 4'd15;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WR_ROW,
        OP_LOAD_T,
        OP_MUL,
        OP_ACC_CLR,
        OP_ACC_ADD,
        OP_COF_WR,
        OP_T_RAM,
        OP_DET_SET,
        OP_DETQ,
        OP_DIV,
        OP_LANE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] eaddr;   // matrix element select
        logic [3:0] raddr;   // cofactor store address
        logic       neg;     // subtract / negate
        logic [1:0] lane;
        logic [1:0] row;
        logic       last;
    } m4i_cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic div_busy;
        logic out_valid;
    } m4i_stat_t;

    // column of the minor taken from minor row i in expansion term k
    function automatic logic [1:0] term_col(input logic [2:0] k, input logic [1:0] i);
        logic [5:0] p;
        begin
            case (k)
                3'd0: p = {2'd2, 2'd1, 2'd0};
                3'd1: p = {2'd0, 2'd2, 2'd1};
                3'd2: p = {2'd1, 2'd0, 2'd2};
                3'd3: p = {2'd1, 2'd2, 2'd0};
                3'd4: p = {2'd2, 2'd0, 2'd1};
                default: p = {2'd0, 2'd1, 2'd2};
            endcase
            term_col = p[i*2 +: 2];
        end
    endfunction

    // element address of minor entry (i, j) for cofactor (r, c)
    function automatic logic [3:0] minor_addr(input logic [1:0] r, input logic [1:0] c,
                                              input logic [1:0] i, input logic [1:0] j);
        logic [1:0] rr;
        logic [1:0] cc;
        begin
            rr = (i < r) ? i : i + 2'd1;
            cc = (j < c) ? j : j + 2'd1;
            minor_addr = {rr, cc};
        end
    endfunction

endpackage

/* hdl/m4i_ram.sv */
// ----------------------------------------------------------------------------
// m4i_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module m4i_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/m4i_ctrl.sv */
// ----------------------------------------------------------------------------
// m4i_ctrl
// Sequencer: row loading, cofactor expansion, determinant, division, output.
// ----------------------------------------------------------------------------
module m4i_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  m4i_pkg::m4i_stat_t  stat,
    output m4i_pkg::m4i_cmd_t   cmd
);
    import m4i_pkg::*;

    typedef enum logic [21:0] {
        S_LOAD = 22'h000001,
        S_CLR  = 22'h000002,
        S_T0   = 22'h000004,
        S_M1   = 22'h000008,
        S_W1   = 22'h000010,
        S_M2   = 22'h000020,
        S_W2   = 22'h000040,
        S_ACC  = 22'h000080,
        S_COF  = 22'h000100,
        S_DCLR = 22'h000200,
        S_DRD  = 22'h000400,
        S_DT   = 22'h000800,
        S_DM   = 22'h001000,
        S_DW   = 22'h002000,
        S_DACC = 22'h004000,
        S_DSET = 22'h008000,
        S_DQ   = 22'h010000,
        S_VRD  = 22'h020000,
        S_VDIV = 22'h040000,
        S_VW   = 22'h080000,
        S_VPUT = 22'h100000,
        S_OUT  = 22'h200000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] rows_reg, rows_next;
    logic [3:0] ci_reg, ci_next;
    logic [2:0] k_reg, k_next;
    logic [1:0] j_reg, j_next;
    logic [1:0] i_reg, i_next;

    always_comb
    begin
        state_next = state_reg;
        rows_next  = rows_reg;
        ci_next    = ci_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op    = OP_WR_ROW;
                    cmd.row   = rows_reg;
                    rows_next = rows_reg + 2'd1;
                    if (rows_reg == ROW_LAST)
                    begin
                        ci_next    = '0;
                        state_next = S_CLR;
                    end
                end
            end
            S_CLR:
            begin
                cmd.op     = OP_ACC_CLR;
                k_next     = '0;
                state_next = S_T0;
            end
            S_T0:
            begin
                cmd.op     = OP_LOAD_T;
                cmd.eaddr  = minor_addr(ci_reg[3:2], ci_reg[1:0], 2'd0, term_col(k_reg, 2'd0));
                state_next = S_M1;
            end
            S_M1:
            begin
                cmd.op     = OP_MUL;
                cmd.eaddr  = minor_addr(ci_reg[3:2], ci_reg[1:0], 2'd1, term_col(k_reg, 2'd1));
                state_next = S_W1;
            end
            S_W1:
            begin
                if (!stat.mul_busy)
                begin
                    state_next = S_M2;
                end
            end
            S_M2:
            begin
                cmd.op     = OP_MUL;
                cmd.eaddr  = minor_addr(ci_reg[3:2], ci_reg[1:0], 2'd2, term_col(k_reg, 2'd2));
                state_next = S_W2;
            end
            S_W2:
            begin
                if (!stat.mul_busy)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.op  = OP_ACC_ADD;
                cmd.neg = (k_reg >= TERM_NEG_FIRST);
                k_next  = k_reg + 3'd1;
                state_next = (k_reg == TERM_LAST) ? S_COF : S_T0;
            end
            S_COF:
            begin
                cmd.op    = OP_COF_WR;
                cmd.raddr = ci_reg;
                cmd.neg   = ci_reg[2] ^ ci_reg[0];   // (-1)^(row+col)
                ci_next   = ci_reg + 4'd1;
                state_next = (ci_reg == COF_LAST) ? S_DCLR : S_CLR;
            end
            S_DCLR:
            begin
                cmd.op     = OP_ACC_CLR;
                j_next     = '0;
                state_next = S_DRD;
            end
            S_DRD:
            begin
                cmd.raddr  = {2'd0, j_reg};
                state_next = S_DT;
            end
            S_DT:
            begin
                cmd.op     = OP_T_RAM;
                state_next = S_DM;
            end
            S_DM:
            begin
                cmd.op     = OP_MUL;
                cmd.eaddr  = {2'd0, j_reg};
                state_next = S_DW;
            end
            S_DW:
            begin
                if (!stat.mul_busy)
                begin
                    state_next = S_DACC;
                end
            end
            S_DACC:
            begin
                cmd.op     = OP_ACC_ADD;
                j_next     = j_reg + 2'd1;
                state_next = (j_reg == ROW_LAST) ? S_DSET : S_DRD;
            end
            S_DSET:
            begin
                cmd.op     = OP_DET_SET;
                state_next = S_DQ;
            end
            S_DQ:
            begin
                cmd.op     = OP_DETQ;
                i_next     = '0;
                j_next     = '0;
                state_next = S_VRD;
            end
            S_VRD:
            begin
                cmd.raddr  = {j_reg, i_reg};   // adjugate = transposed cofactors
                state_next = S_VDIV;
            end
            S_VDIV:
            begin
                cmd.op     = OP_DIV;
                state_next = S_VW;
            end
            S_VW:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_VPUT;
                end
            end
            S_VPUT:
            begin
                cmd.op     = OP_LANE;
                cmd.lane   = j_reg;
                j_next     = j_reg + 2'd1;
                state_next = (j_reg == ROW_LAST) ? S_OUT : S_VRD;
            end
            S_OUT:
            begin
                if (!stat.out_valid)
                begin
                    cmd.op   = OP_EMIT;
                    cmd.row  = i_reg;
                    cmd.last = (i_reg == ROW_LAST);
                    i_next   = i_reg + 2'd1;
                    state_next = (i_reg == ROW_LAST) ? S_LOAD : S_VRD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            rows_reg  <= '0;
            ci_reg    <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rows_reg  <= rows_next;
            ci_reg    <= ci_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            i_reg     <= i_next;
        end
    end

    // no arithmetic unit may still run while rows are being taken
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOAD |-> !stat.mul_busy && !stat.div_busy)
        else $error("unit busy during row load");

    // an output row is only issued into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EMIT |-> !stat.out_valid)
        else $error("emit over pending output");

endmodule

/* hdl/m4i_dp.sv */
// ----------------------------------------------------------------------------
// m4i_dp
// Datapath: element store, serial multiplier, accumulator, cofactor RAM,
// restoring divider, rounding/saturation and output register.
// ----------------------------------------------------------------------------
module m4i_dp #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int IN_W       = 128,
    parameter int OUT_W      = 200
) (
    input  logic                clk,
    input  logic                rst_n,
    input  m4i_pkg::m4i_cmd_t   cmd,
    output m4i_pkg::m4i_stat_t  stat,
    input  logic [IN_W-1:0]     s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);
    import m4i_pkg::*;

    localparam int EW  = ELEM_WIDTH;
    localparam int W   = 4 * EW + 2 * FRAC_BITS + 8;
    localparam int MCW = $clog2(EW + 1);
    localparam int DCW = $clog2(W + 1);
    localparam logic [W-1:0] HALF = W'(1) << (2 * FRAC_BITS - 1);

    logic [EW-1:0]  mat_reg [16];
    logic [W-1:0]   t_reg, acc_reg;
    logic [W-1:0]   det_abs_reg;
    logic           det_neg_reg, sing_reg;
    logic [DET_BITS-1:0] detq_reg;
    // multiplier
    logic [W-1:0]   mc_reg, pr_reg;
    logic [EW-1:0]  mp_reg;
    logic           mneg_reg, mfin_reg;
    logic [MCW-1:0] mcnt_reg;
    // divider
    logic [W-1:0]   dd_reg, q_reg;
    logic [W:0]     rem_reg, dv_reg;
    logic           dneg_reg;
    logic [DCW-1:0] dcnt_reg;
    // result lanes and output register
    logic [EW-1:0]  lane_reg [4];
    logic [EW-1:0]  oinv_reg [4];
    logic           ov_reg;
    logic [1:0]     orow_reg;
    logic [DET_BITS-1:0] odet_reg;
    logic           osing_reg, olast_reg;

    logic [W-1:0]   ram_q, cof_wdata;
    logic [EW-1:0]  elem_sel, elem_mag;
    logic [W-1:0]   pr_next, prod_res, acc_next, det_abs_next;
    logic [W-1:0]   rnd, detq_val, n_abs, dd_start;
    logic [W:0]     r1;
    logic           r_ge;
    logic [W-1:0]   quot;
    logic [EW-1:0]  quot_sat;
    logic [DET_BITS-1:0] detq_sat;

    m4i_ram #(.WIDTH(W), .DEPTH(16)) u_cof_ram (
        .clk   (clk),
        .we    (cmd.op == OP_COF_WR),
        .waddr (cmd.raddr),
        .wdata (cof_wdata),
        .raddr (cmd.raddr),
        .rdata (ram_q)
    );

    always_comb
    begin
        elem_sel     = mat_reg[cmd.eaddr];
        elem_mag     = elem_sel[EW-1] ? (~elem_sel + 1'b1) : elem_sel;
        pr_next      = mp_reg[0] ? pr_reg + mc_reg : pr_reg;
        prod_res     = mneg_reg ? (~pr_reg + 1'b1) : pr_reg;
        acc_next     = cmd.neg ? acc_reg - t_reg : acc_reg + t_reg;
        cof_wdata    = cmd.neg ? (~acc_reg + 1'b1) : acc_reg;
        det_abs_next = acc_reg[W-1] ? (~acc_reg + 1'b1) : acc_reg;
        // det / 2^(2F), nearest, ties away from zero
        rnd          = (det_abs_reg + HALF) >> (2 * FRAC_BITS);
        detq_val     = det_neg_reg ? (~rnd + 1'b1) : rnd;
        if ((&detq_val[W-1:DET_BITS-1]) || !(|detq_val[W-1:DET_BITS-1]))
        begin
            detq_sat = detq_val[DET_BITS-1:0];
        end
        else
        begin
            detq_sat = {detq_val[W-1], {(DET_BITS-1){~detq_val[W-1]}}};
        end
        // quotient = (2|n| + |d|) / 2|d| with n = adj << 2F
        n_abs    = ram_q[W-1] ? (~ram_q + 1'b1) : ram_q;
        dd_start = (n_abs << (2 * FRAC_BITS + 1)) + det_abs_reg;
        r1       = {rem_reg[W-1:0], dd_reg[W-1]};
        r_ge     = (r1 >= dv_reg);
        quot     = dneg_reg ? (~q_reg + 1'b1) : q_reg;
        if ((&quot[W-1:EW-1]) || !(|quot[W-1:EW-1]))
        begin
            quot_sat = quot[EW-1:0];
        end
        else
        begin
            quot_sat = {quot[W-1], {(EW-1){~quot[W-1]}}};
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcnt_reg <= '0;
            mfin_reg <= 1'b0;
            dcnt_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_MUL)
            begin
                mcnt_reg <= MCW'(EW);
            end
            else if (mcnt_reg != '0)
            begin
                mcnt_reg <= mcnt_reg - 1'b1;
            end
            mfin_reg <= (mcnt_reg == MCW'(1));
            if (cmd.op == OP_DIV)
            begin
                dcnt_reg <= DCW'(W);
            end
            else if (dcnt_reg != '0)
            begin
                dcnt_reg <= dcnt_reg - 1'b1;
            end
            if (cmd.op == OP_EMIT)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (mcnt_reg != '0)
        begin
            pr_reg <= pr_next;
            mc_reg <= mc_reg << 1;
            mp_reg <= mp_reg >> 1;
        end
        if (mfin_reg)
        begin
            t_reg <= prod_res;
        end
        if (dcnt_reg != '0)
        begin
            dd_reg  <= dd_reg << 1;
            rem_reg <= r_ge ? r1 - dv_reg : r1;
            q_reg   <= {q_reg[W-2:0], r_ge};
        end
        case (cmd.op)
            OP_WR_ROW:
            begin
                for (int n = 0; n < 4; n++)
                begin
                    mat_reg[{cmd.row, 2'(n)}] <= s_tdata[n*EW +: EW];
                end
            end
            OP_LOAD_T:
            begin
                t_reg <= {{(W-EW){elem_sel[EW-1]}}, elem_sel};
            end
            OP_MUL:
            begin
                mc_reg   <= t_reg;
                mp_reg   <= elem_mag;
                mneg_reg <= elem_sel[EW-1];
                pr_reg   <= '0;
            end
            OP_ACC_CLR:
            begin
                acc_reg <= '0;
            end
            OP_ACC_ADD:
            begin
                acc_reg <= acc_next;
            end
            OP_T_RAM:
            begin
                t_reg <= ram_q;
            end
            OP_DET_SET:
            begin
                det_abs_reg <= det_abs_next;
                det_neg_reg <= acc_reg[W-1];
                sing_reg    <= (acc_reg == '0);
            end
            OP_DETQ:
            begin
                detq_reg <= sing_reg ? '0 : detq_sat;
            end
            OP_DIV:
            begin
                dd_reg   <= dd_start;
                dv_reg   <= {det_abs_reg, 1'b0};
                rem_reg  <= '0;
                q_reg    <= '0;
                dneg_reg <= ram_q[W-1] ^ det_neg_reg;
            end
            OP_LANE:
            begin
                lane_reg[cmd.lane] <= sing_reg ? '0 : quot_sat;
            end
            OP_EMIT:
            begin
                oinv_reg  <= lane_reg;
                orow_reg  <= cmd.row;
                odet_reg  <= detq_reg;
                osing_reg <= sing_reg;
                olast_reg <= cmd.last;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.mul_busy  = (mcnt_reg != '0) || mfin_reg;
        stat.div_busy  = (dcnt_reg != '0);
        stat.out_valid = ov_reg;
        m_tvalid = ov_reg;
        m_tuser  = osing_reg;
        m_tlast  = olast_reg;
        m_tdata  = '0;
        for (int n = 0; n < 4; n++)
        begin
            m_tdata[n*EW +: EW] = oinv_reg[n];
        end
        m_tdata[4*EW +: 2] = orow_reg;
        m_tdata[4*EW+2 +: DET_BITS] = odet_reg;
    end

endmodule

/* hdl/matrix4_inverse_adjugate_core.sv */
// ----------------------------------------------------------------------------
// matrix4_inverse_adjugate_core
// 4x4 fixed-point matrix inverse by cofactors, adjugate and determinant.
// ----------------------------------------------------------------------------
// A matrix enters as four row transfers on the slave stream (row 0 first);
// the first three rows only load. After the fourth the core expands all
// sixteen 3x3 minors exactly, forms the determinant from row 0, rounds it to
// Q32.32 and divides every adjugate element by it, then sends four inverse
// rows on the master stream, row 3 with tlast. A zero determinant raises
// tuser (singular) and zeroes inverse and determinant fields. Out-of-range
// values clamp. Work is serial: one shift-add multiplier and one restoring
// divider (one quotient bit a cycle, W = 4*ELEM_WIDTH + 2*FRAC_BITS + 8
// bits); rows are refused while a matrix is worked on. The result register
// frees the core to start the next row while the last output row waits to
// be taken.
// ----------------------------------------------------------------------------
module matrix4_inverse_adjugate_core #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,
    // s_tdata: elem_a, elem_b, elem_c, elem_d (ELEM_WIDTH each), zero pad
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((4*ELEM_WIDTH+7)/8)*8-1:0]      s_tdata,
    // m_tdata: inv_a, inv_b, inv_c, inv_d (ELEM_WIDTH each), out_row (2),
    //          det_value (64), zero pad
    // m_tuser: singular;  m_tlast: last_row
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((4*ELEM_WIDTH+66+7)/8)*8-1:0]   m_tdata,
    output logic                                   m_tuser,
    output logic                                   m_tlast
);
    import m4i_pkg::*;

    localparam int IN_W  = ((4 * ELEM_WIDTH + 7) / 8) * 8;
    localparam int OUT_W = ((4 * ELEM_WIDTH + META_BITS + 7) / 8) * 8;
    localparam int ROW_LSB = 4 * ELEM_WIDTH;

    m4i_cmd_t  cmd;
    m4i_stat_t stat;

    // sequencer
    m4i_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and storage
    m4i_dp #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .IN_W       (IN_W),
        .OUT_W      (OUT_W)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // tlast marks exactly the row with index 3
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[ROW_LSB +: 2] == ROW_LAST)))
        else $error("tlast does not match row index");

    // singular output carries zero inverse and determinant
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            (m_tdata[ROW_LSB-1:0] == '0) && (m_tdata[ROW_LSB+2 +: DET_BITS] == '0))
        else $error("singular transfer with nonzero data");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4x4 adjugate inverse core.
// ----------------------------------------------------------------------------
// Matrices go in as four row transfers. A scoreboard keeps its own exact
// model: wide signed cofactors, determinant, rounded division and clamping.
// Each output row is compared field by field with the oldest prediction.
// Both streams idle at random, and the output side holds off once for a
// long stretch so that the core backs up and refuses rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class inverse_scoreboard;
    typedef logic signed [255:0] wide_t;
    typedef struct {
        logic [31:0] inv [4];
        logic [1:0]  row;
        logic [63:0] det;
        logic        sing;
        logic        last;
    } inv_row_t;

    inv_row_t    pending_rows[$];
    logic [31:0] mat [4][4];
    int          rows_in;
    int          errors;
    int          checked;
    int          matrices;
    int          singular_seen;

    function new();
        rows_in = 0;
        errors = 0;
        checked = 0;
        matrices = 0;
        singular_seen = 0;
    endfunction

    function wide_t elem(int r, int c);
        wide_t v;
        v = signed'(mat[r][c]);
        return v;
    endfunction

    // signed cofactor of (r, c): minor with sign (-1)^(r+c)
    function wide_t cofactor(int r, int c);
        wide_t e [3][3];
        wide_t s;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                e[i][j] = elem(i < r ? i : i + 1, j < c ? j : j + 1);
        s = e[0][0]*e[1][1]*e[2][2] + e[0][1]*e[1][2]*e[2][0] + e[0][2]*e[1][0]*e[2][1]
          - e[0][0]*e[1][2]*e[2][1] - e[0][1]*e[1][0]*e[2][2] - e[0][2]*e[1][1]*e[2][0];
        return ((r + c) % 2) ? -s : s;
    endfunction

    // round to nearest, ties away from zero
    function wide_t round_div(wide_t n, wide_t d);
        wide_t an;
        wide_t ad;
        wide_t q;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q = (2 * an + ad) / (2 * ad);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function logic [63:0] clamp(wide_t v, int bits);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (bits - 1)) - 1;
        lo = -(wide_t'(1) <<< (bits - 1));
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[63:0];
    endfunction

    function void note_row(logic [127:0] d);
        wide_t    cof [4][4];
        wide_t    det;
        inv_row_t r;
        for (int j = 0; j < 4; j++)
            mat[rows_in][j] = d[32*j +: 32];
        if (rows_in < 3) begin
            rows_in++;
            return;
        end
        rows_in = 0;
        matrices++;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                cof[i][j] = cofactor(i, j);
        det = 0;
        for (int j = 0; j < 4; j++)
            det = det + elem(0, j) * cof[0][j];
        for (int i = 0; i < 4; i++) begin
            r.sing = (det == 0);
            r.det = r.sing ? 64'd0 : clamp(round_div(det, wide_t'(1) <<< 32), 64);
            for (int j = 0; j < 4; j++)
                r.inv[j] = r.sing ? 32'd0
                         : 32'(clamp(round_div(cof[j][i] <<< 32, det), 32));
            r.row = 2'(i);
            r.last = (i == 3);
            pending_rows.push_back(r);
        end
    endfunction

    function void check_row(logic [199:0] d, logic user, logic last);
        inv_row_t e;
        if (pending_rows.size() == 0) begin
            $display("%0t: unexpected output row, data %h", $time, d);
            errors++;
            return;
        end
        e = pending_rows.pop_front();
        checked++;
        if (e.sing) singular_seen++;
        for (int j = 0; j < 4; j++)
            if (d[32*j +: 32] !== e.inv[j]) begin
                $display("%0t: row %0d col %0d expected %h actual %h",
                         $time, e.row, j, e.inv[j], d[32*j +: 32]);
                errors++;
            end
        if (d[129:128] !== e.row) begin
            $display("%0t: out_row expected %0d actual %0d", $time, e.row, d[129:128]);
            errors++;
        end
        if (d[193:130] !== e.det) begin
            $display("%0t: det expected %h actual %h", $time, e.det, d[193:130]);
            errors++;
        end
        if (user !== e.sing) begin
            $display("%0t: singular expected %b actual %b", $time, e.sing, user);
            errors++;
        end
        if (last !== e.last) begin
            $display("%0t: last expected %b actual %b", $time, e.last, last);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int RANDOM_MATRICES = 82;
    localparam logic [31:0] ONE = 32'h0001_0000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;     // elem_a, elem_b, elem_c, elem_d
    logic         m_tvalid;
    logic         m_tready;
    logic [199:0] m_tdata;     // inv_a..inv_d, out_row, det_value, pad
    logic         m_tuser;     // singular
    logic         m_tlast;     // last_row

    inverse_scoreboard inv_sb;
    int  cycles;
    bit  hold_req;
    int  hold_left;
    int  stall_left;

    matrix4_inverse_adjugate_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    task automatic send_row(input logic [127:0] d);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge clk); while (!s_tready);
        inv_sb.note_row(d);
    endtask

    task automatic send_matrix(input logic [31:0] m [4][4]);
        for (int r = 0; r < 4; r++)
            send_row({m[r][3], m[r][2], m[r][1], m[r][0]});
    endtask

    function automatic logic [31:0] rand_elem(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
            default: return 32'($signed($urandom() >>> $urandom_range(0, 31)));
        endcase
    endfunction

    // output side: check at the rising edge, pick tready at the falling edge
    initial
    begin
        m_tready = 1'b0;
        hold_left = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                inv_sb.check_row(m_tdata, m_tuser, m_tlast);
            @(negedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_req = 1'b0;
                hold_left = 30000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 9) < 3) stall_left = pick_gap();
            end
        end
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] m [4][4];
        int kind;
        int src;
        inv_sb = new();
        hold_req = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // identity
        foreach (m[r, c]) m[r][c] = (r == c) ? ONE : 32'd0;
        send_matrix(m);
        // zero matrix: singular
        foreach (m[r, c]) m[r][c] = 32'd0;
        send_matrix(m);
        // all maximum, then all minimum: rank one, singular
        foreach (m[r, c]) m[r][c] = 32'h7fff_ffff;
        send_matrix(m);
        foreach (m[r, c]) m[r][c] = 32'h8000_0000;
        send_matrix(m);
        // diagonal of one lsb: determinant rounds to zero but is not singular,
        // inverse clamps high
        foreach (m[r, c]) m[r][c] = (r == c) ? 32'd1 : 32'd0;
        send_matrix(m);
        // odd permutation with extreme entries, positive determinant
        foreach (m[r, c]) m[r][c] = 32'd0;
        m[0][1] = 32'h8000_0000;
        m[1][0] = 32'h7fff_ffff;
        m[2][2] = 32'hffff_ffff;
        m[3][3] = 32'h8000_0000;
        send_matrix(m);

        for (int n = 0; n < RANDOM_MATRICES; n++)
        begin
            kind = $urandom_range(0, 2);
            foreach (m[r, c]) m[r][c] = rand_elem(kind);
            if (kind == 1)
                for (int r = 0; r < 4; r++) m[r][r] = m[r][r] + 4 * ONE;
            // occasional repeated row forces a singular matrix
            if ($urandom_range(0, 9) == 0)
            begin
                src = $urandom_range(0, 2);
                for (int c = 0; c < 4; c++) m[3][c] = m[src][c];
            end
            // once, stall the output long enough for the core to back up
            if (n == 10) hold_req = 1'b1;
            send_matrix(m);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (inv_sb.pending_rows.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d matrices, %0d rows checked, %0d singular rows",
                 inv_sb.matrices, inv_sb.checked, inv_sb.singular_seen);
        if (inv_sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
